FILE: src/first_fit_region_allocator_defines.svh
// Assertion macros for the first-fit region allocator checker.
// No dependencies; included by the checker file only.
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ffra_pkg.sv
// Shared constants, types and helpers of the first-fit region allocator.
// No dependencies; used by every module of the block.
package ffra_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int OFS_W       = 16;
    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 32;
    localparam int CUR_W       = OFS_W + 1;
    localparam int CMP_W       = (CUR_W > SIZE_W + 1) ? CUR_W : SIZE_W + 1;

    localparam int IN_W        = 48;
    localparam int OUT_W       = 40;
    localparam int OUT_STAT_LSB = ADDR_W;
    localparam int PADDR_W     = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_SIZE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One table entry as held by a cell; stop is start plus length.
    typedef struct packed {
        logic             valid;
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] len;
        logic [CUR_W-1:0] stop;
    } ent_t;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic              eval;
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] ofs;
        logic [SIZE_W-1:0] pool_size;
    } cmd_t;

    // Per-cell update select at commit.
    typedef struct packed {
        logic load_new;
        logic from_left;
        logic from_right;
    } upd_t;

    // Request size as stored in an entry: kept to OFS_W bits.
    function automatic logic [OFS_W-1:0] fit_len(input logic [SIZE_W-1:0] size);
        logic [SIZE_W+OFS_W-1:0] wide;
        wide = (SIZE_W + OFS_W)'(size);
        return wide[OFS_W-1:0];
    endfunction

endpackage

FILE: src/first_fit_region_allocator.sv
// First-fit region allocator. Each transaction on the slave stream is an allocate or a free
// request against one pool of pool_size bytes at pool_base; each gives exactly one result
// transaction on the master stream. The live regions sit in a chain of MAX_ENTRIES cells,
// packed and ordered by start offset. A transaction is latched at its accepting edge and then
// passes an evaluation state, in which every cell tests its own gap (or address match) in
// parallel and registers its hit, then a commit state, in which the first hit is picked, the
// chain shifts one place and the result register is loaded. A new transaction can be taken in
// the same cycle as the commit, but not during evaluation; the commit waits only while the
// previous result is still held on the master side. No clearing pass is needed after reset.
// The block is built from ffra_pkg and ffra_cell.
module first_fit_region_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    // Slave stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ffra_pkg::IN_W-1:0]      s_tdata,  // request_size[15:0], release_address[47:16]
    input  logic                           s_tuser,  // kind (0 allocate, 1 free)
    // Master stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ffra_pkg::OUT_W-1:0]     m_tdata,  // granted_address[31:0], status[33:32]
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffra_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ffra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;

    // Configuration registers.
    logic [ADDR_W-1:0]   pool_base_reg;
    logic [SIZE_W-1:0]   pool_size_reg;
    logic                cfg_write;

    // The transaction being worked on.
    logic                kind_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   ofs_reg;

    // Result register.
    logic                m_tvalid_reg;
    logic [ADDR_W-1:0]   grant_reg;
    status_t             status_reg;

    logic                accept;
    logic                commit_go;
    cmd_t                cmd;
    upd_t                upd    [MAX_ENTRIES];
    ent_t                ent_w  [MAX_ENTRIES];
    logic [CUR_W-1:0]    cur_w  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] flags;
    logic [MAX_ENTRIES-1:0] lower_hit;
    logic [MAX_ENTRIES-1:0] first;
    logic                found;
    logic                full;
    logic                alloc_ok;
    logic                free_ok;
    logic [CUR_W-1:0]    cur_sel;
    ent_t                new_ent;
    status_t             status_calc;
    logic [ADDR_W-1:0]   grant_calc;

    // ------------------------------------------------------------------
    // Configuration port: writes complete in the access phase, never stall.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_POOL_SIZE) ? 32'(pool_size_reg) : pool_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            pool_size_reg <= '1;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_POOL_BASE)
            begin
                pool_base_reg <= pwdata;
            end
            else
            begin
                pool_size_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. The commit cycle also takes the next transaction, whose
    // evaluation then sees the chain as this commit leaves it.
    // ------------------------------------------------------------------
    assign commit_go = (state_reg == S_COMMIT) && (!m_tvalid_reg || m_tready);
    assign s_tready  = (state_reg == S_IDLE) || commit_go;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = s_tvalid ? S_EVAL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The release address is turned into a pool offset as it is latched.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser;
            size_reg <= s_tdata[SIZE_W-1:0];
            ofs_reg  <= s_tdata[SIZE_W +: ADDR_W] - pool_base_reg;
        end
    end

    always_comb
    begin
        cmd.eval      = (state_reg == S_EVAL);
        cmd.kind      = kind_reg;
        cmd.size      = size_reg;
        cmd.ofs       = ofs_reg;
        cmd.pool_size = pool_size_reg;
    end

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 sees a valid neighbour ending at offset zero, so
    // the gap at the pool start is tested like any other; the last cell
    // pulls in an empty entry when the chain closes up after a free.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        ent_t left_ent;
        ent_t right_ent;

        if (i == 0)
        begin : g_lb
            assign left_ent = '{valid: 1'b1, start: '0, len: '0, stop: '0};
        end
        else
        begin : g_ln
            assign left_ent = ent_w[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_rb
            assign right_ent = '0;
        end
        else
        begin : g_rn
            assign right_ent = ent_w[i+1];
        end

        ffra_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .upd     (upd[i]),
            .new_ent (new_ent),
            .left    (left_ent),
            .right   (right_ent),
            .ent     (ent_w[i]),
            .cursor  (cur_w[i]),
            .flag    (flags[i])
        );
    end

    // ------------------------------------------------------------------
    // Commit: the lowest cell that hit wins. For an allocate, the winner
    // takes the new region and every cell above it takes its left
    // neighbour; for a free, the winner and every cell above it take the
    // right neighbour.
    // ------------------------------------------------------------------
    always_comb
    begin
        lower_hit[0] = 1'b0;
        for (int i = 1; i < MAX_ENTRIES; i++)
        begin
            lower_hit[i] = lower_hit[i-1] | flags[i-1];
        end
        first = flags & ~lower_hit;
        found = |flags;
        full  = ent_w[MAX_ENTRIES-1].valid;

        cur_sel = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            cur_sel = cur_sel | ({CUR_W{first[i]}} & cur_w[i]);
        end
    end

    assign alloc_ok = (kind_reg == KIND_ALLOC) && (size_reg != '0) && !full && found;
    assign free_ok  = (kind_reg == KIND_FREE) && found;

    always_comb
    begin
        new_ent.valid = 1'b1;
        new_ent.start = cur_sel[OFS_W-1:0];
        new_ent.len   = fit_len(size_reg);
        new_ent.stop  = CUR_W'(cur_sel[OFS_W-1:0]) + CUR_W'(fit_len(size_reg));
        grant_calc    = pool_base_reg + ADDR_W'(cur_sel);
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            upd[i].load_new   = commit_go && alloc_ok && first[i];
            upd[i].from_left  = commit_go && alloc_ok && lower_hit[i];
            upd[i].from_right = commit_go && free_ok && (first[i] || lower_hit[i]);
        end
    end

    always_comb
    begin
        if (kind_reg == KIND_FREE)
        begin
            status_calc = found ? ST_OK : ST_NOT_FOUND;
        end
        else if (size_reg == '0)
        begin
            status_calc = ST_NO_SPACE;
        end
        else if (full)
        begin
            status_calc = ST_FULL;
        end
        else if (!found)
        begin
            status_calc = ST_NO_SPACE;
        end
        else
        begin
            status_calc = ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Result register: holds one result while the master side stalls.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit_go)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_go)
        begin
            grant_reg  <= alloc_ok ? grant_calc : '0;
            status_reg <= status_calc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_W - ADDR_W - 2)'(0), status_reg, grant_reg};

endmodule

FILE: src/ffra_cell.sv
// One cell of the allocator's entry chain: holds one region and tests it.
// Depends on ffra_pkg.
module ffra_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  ffra_pkg::cmd_t cmd,
    input  ffra_pkg::upd_t upd,
    input  ffra_pkg::ent_t new_ent,
    input  ffra_pkg::ent_t left,
    input  ffra_pkg::ent_t right,
    output ffra_pkg::ent_t ent,
    output logic [ffra_pkg::CUR_W-1:0] cursor,
    output logic           flag
);
    import ffra_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    ent_t             data_reg;
    ent_t             data_next;
    logic             flag_reg;
    logic             flag_next;
    logic [CMP_W-1:0] s_c;
    logic [CMP_W-1:0] cur_c;
    logic [CMP_W-1:0] sz_c;
    logic [CMP_W-1:0] ps_c;
    logic             gap_fit;
    logic             tail_fit;
    logic             first_free;
    logic             alloc_hit;
    logic             free_hit;

    // The cursor is where the region to the left ends.
    assign cursor = left.stop;

    always_comb
    begin
        s_c        = CMP_W'(data_reg.start);
        cur_c      = CMP_W'(left.stop);
        sz_c       = CMP_W'(cmd.size);
        ps_c       = CMP_W'(cmd.pool_size);
        gap_fit    = (s_c >= cur_c) && ((s_c - cur_c) >= sz_c);
        tail_fit   = (cur_c < ps_c) && ((ps_c - cur_c) >= sz_c);
        first_free = !valid_reg && left.valid;
        alloc_hit  = valid_reg ? gap_fit : (first_free && tail_fit);
        free_hit   = valid_reg && (ADDR_W'(data_reg.start) == cmd.ofs);
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (upd.load_new)
        begin
            valid_next = 1'b1;
            data_next  = new_ent;
        end
        else if (upd.from_left)
        begin
            valid_next = left.valid;
            data_next  = left;
        end
        else if (upd.from_right)
        begin
            valid_next = right.valid;
            data_next  = right;
        end
        flag_next = flag_reg;
        if (cmd.eval)
        begin
            flag_next = (cmd.kind == KIND_ALLOC) ? alloc_hit : free_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        ent       = data_reg;
        ent.valid = valid_reg;
    end

    assign flag = flag_reg;

endmodule

FILE: src/ffra_checker.sv
// Port-level checker for the first-fit region allocator, bound to its top level.
// Depends on ffra_pkg and first_fit_region_allocator_defines.svh.
`include "first_fit_region_allocator_defines.svh"

module ffra_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ffra_pkg::OUT_W-1:0] m_tdata
);
    import ffra_pkg::*;

    // Only a successful allocate carries an address.
    `FFRA_ASSERT_NOW(a_grant_zero, m_tvalid && (m_tdata[OUT_STAT_LSB +: 2] != ST_OK) && (m_tdata[ADDR_W-1:0] != '0), 1'b0, "address returned with a failing status")

    // A transaction always passes through evaluation before the next is taken.
    `FFRA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken on consecutive cycles")

    // A stalled result stays put.
    `FFRA_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (.*);

FILE: verif/region_table_checker.sv
// Checker for the first-fit region allocator: keeps its own copy of the region table,
// predicts the outcome of every accepted request and compares it with the result stream.
// Depends on ffra_pkg for widths, kinds, register indexes and status codes.
module region_table_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [ffra_pkg::IN_W-1:0]    s_tdata,   // request_size[15:0], release_address[47:16]
    input  logic                         s_tuser,   // kind
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [ffra_pkg::OUT_W-1:0]   m_tdata,   // granted_address[31:0], status[33:32]
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [ffra_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output int                           mismatch_count,
    output int                           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ffra_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] granted;
        status_t           status;
    } outcome_t;

    outcome_t          outcome_q[$];
    outcome_t          oldest;
    logic [ADDR_W-1:0] pool_base_reg;
    logic [SIZE_W-1:0] pool_size_reg;
    logic [OFS_W-1:0]  region_start [MAX_ENTRIES];
    logic [OFS_W-1:0]  region_len   [MAX_ENTRIES];
    int                live_regions;
    int                fail_total;

    // Applies one request to the shadow table and returns the outcome it should give.
    function automatic outcome_t apply_request(input logic kind, input logic [SIZE_W-1:0] req,
                                               input logic [ADDR_W-1:0] addr);
        outcome_t          res;
        int                cursor;
        int                slot;
        int                hit;
        int                i;
        logic              found;
        logic [ADDR_W-1:0] ofs;
        res.granted = '0;
        res.status  = ST_OK;
        if (kind == KIND_ALLOC)
        begin
            if (req == '0)
                res.status = ST_NO_SPACE;
            else if (live_regions >= MAX_ENTRIES)
                res.status = ST_FULL;
            else
            begin
                cursor = 0;
                slot   = live_regions;
                found  = 1'b0;
                for (i = 0; i < live_regions; i++)
                begin
                    if (!found)
                    begin
                        if (int'(region_start[i]) >= cursor &&
                            int'(region_start[i]) - cursor >= int'(req))
                        begin
                            found = 1'b1;
                            slot  = i;
                        end
                        else
                            cursor = int'(region_start[i]) + int'(region_len[i]);
                    end
                end
                // The tail gap is empty once the last region reaches the pool end.
                if (!found && cursor < int'(pool_size_reg) &&
                    int'(pool_size_reg) - cursor >= int'(req))
                    found = 1'b1;
                if (!found)
                    res.status = ST_NO_SPACE;
                else
                begin
                    for (i = live_regions; i > slot; i--)
                    begin
                        region_start[i] = region_start[i-1];
                        region_len[i]   = region_len[i-1];
                    end
                    region_start[slot] = OFS_W'(cursor);
                    region_len[slot]   = req;
                    live_regions++;
                    res.granted = pool_base_reg + ADDR_W'(cursor);
                end
            end
        end
        else
        begin
            // Addresses below the base wrap to huge offsets and so match nothing.
            ofs = addr - pool_base_reg;
            hit = -1;
            for (i = 0; i < live_regions; i++)
                if (hit < 0 && ADDR_W'(region_start[i]) == ofs)
                    hit = i;
            if (hit < 0)
                res.status = ST_NOT_FOUND;
            else
            begin
                for (i = hit; i < live_regions - 1; i++)
                begin
                    region_start[i] = region_start[i+1];
                    region_len[i]   = region_len[i+1];
                end
                live_regions--;
            end
        end
        return res;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t ns: %s wrong, expected %h, got %h", $time, what, exp_val, act_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outcome_q.delete();
            pool_base_reg  = '0;
            pool_size_reg  = '1;
            live_regions   = 0;
            fail_total     = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                    note_failure("unexpected result transaction", '0, m_tdata[31:0]);
                else
                begin
                    oldest = outcome_q.pop_front();
                    if (m_tdata[ADDR_W-1:0] !== oldest.granted)
                        note_failure("granted_address", oldest.granted, m_tdata[ADDR_W-1:0]);
                    if (m_tdata[OUT_STAT_LSB +: 2] !== oldest.status)
                        note_failure("status", 32'(oldest.status), 32'(m_tdata[OUT_STAT_LSB +: 2]));
                end
            end
            if (s_tvalid && s_tready)
                outcome_q.push_back(apply_request(s_tuser, s_tdata[SIZE_W-1:0],
                                                  s_tdata[SIZE_W +: ADDR_W]));
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_POOL_BASE, 2'b00})
                    pool_base_reg = pwdata;
                else if (paddr == {REG_POOL_SIZE, 2'b00})
                    pool_size_reg = pwdata[SIZE_W-1:0];
            end
            mismatch_count <= fail_total;
            pending_count  <= outcome_q.size();
        end
    end

endmodule

FILE: verif/tb_first_fit_region_allocator.sv
// Top of the first-fit region allocator testbench: clock, reset, request and register
// stimulus, result-side back-pressure, a watchdog and the final verdict.
// Depends on ffra_pkg, the allocator RTL and region_table_checker.
module tb_first_fit_region_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import ffra_pkg::*;

    // Cycles allowed for the block to settle after the last result before the pool
    // registers are touched or the run is judged.
    localparam int DRAIN_CYCLES = 4;
    // Cycles without any stream transaction after which the run is stopped as a failure.
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 6;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatch_count;
    int                 pending_count;

    // Stimulus bookkeeping: the register values last written, the offsets of regions that
    // the block has granted (so that most frees hit a live region) and the kinds of the
    // requests still waiting for their result transaction.
    logic [31:0]        base_now;
    logic [15:0]        pool_now;
    logic [31:0]        live_ofs[$];
    logic               issued_kinds[$];
    logic               done_kind;
    int                 burst_left;
    int                 idle_cycles;
    logic [11:0]        stall_cycle = '0;

    first_fit_region_allocator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    region_table_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The result side stalls on a pattern of its own, cycling through four moods picked by
    // bits 10:9 of a free-running count: always ready, coin-toss, ready only when its low two
    // bits are zero, and long sparse stalls. Because the mood is tied to a free-running count and
    // not to the request stream, the stalls land on every phase of the block's work.
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1'b1;
        case (stall_cycle[10:9])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (stall_cycle[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    // Learn which allocations succeeded, so that later frees can name live regions.
    // Offsets are kept rather than addresses, as the base may move between phases while
    // the regions stay where they are in the pool.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready && issued_kinds.size() > 0)
            begin
                done_kind = issued_kinds.pop_front();
                if (done_kind == KIND_ALLOC && m_tdata[OUT_STAT_LSB +: 2] == ST_OK)
                    live_ofs.push_back(m_tdata[ADDR_W-1:0] - base_now);
            end
            if (s_tvalid && s_tready)
                issued_kinds.push_back(s_tuser);
        end
    end

    // The watchdog counts cycles in which neither stream moves a transaction; a correct
    // run never comes near the limit, even in the sparsest stall mood.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // One request transaction. The sender works in bursts: within a burst the next
    // request follows at once with tvalid held high; between bursts tvalid may drop for a
    // random gap.
    task automatic send_item(input logic kind, input logic [15:0] req,
                             input logic [31:0] addr);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {addr, req};
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait until every predicted result has been seen. The first edge
    // lets the checker's count catch up with a transaction accepted on this very edge.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // A register write: setup cycle, then access cycle held until pready, then the bus returns
    // to idle before the task ends.
    task automatic write_reg(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // The pool registers are only rewritten while the block is idle, so every request
    // in flight is judged against the settings it was accepted under.
    task automatic configure_pool(input logic [31:0] base, input logic [15:0] size);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_POOL_BASE, base);
        write_reg(REG_POOL_SIZE, {16'h0000, size});
        base_now = base;
        pool_now = size;
    endtask

    initial
    begin
        int          phase;
        int          n;
        int          sel;
        int          idx;
        logic [15:0] req;
        logic [31:0] addr;
        logic [31:0] cfg_base;
        logic [15:0] cfg_size;

        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= KIND_ALLOC;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        base_now   = '0;
        pool_now   = '1;
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With the base just above zero, a free of a low address falls
        // below the pool and must wrap to an offset that matches nothing.
        configure_pool(32'h0000_1000, 16'hFFFF);
        // A zero-size request is refused and a free on an empty table finds nothing.
        send_item(KIND_ALLOC, 16'h0000, $urandom());
        send_item(KIND_FREE, 16'($urandom()), 32'h0000_0000);
        // The whole pool in one region, after which not even one byte fits.
        send_item(KIND_ALLOC, 16'hFFFF, $urandom());
        send_item(KIND_ALLOC, 16'h0001, $urandom());
        send_item(KIND_FREE, 16'($urandom()), base_now);
        // Sixteen one-byte regions packed with no slack fill the table.
        for (n = 0; n < MAX_ENTRIES; n++)
            send_item(KIND_ALLOC, 16'h0001, $urandom());
        // A full table refuses even though the tail has room.
        send_item(KIND_ALLOC, 16'hFFFF, $urandom());
        send_item(KIND_FREE, 16'($urandom()), base_now - 1);
        // Freeing an interior region opens a gap that the next allocation must reuse.
        send_item(KIND_FREE, 16'($urandom()), base_now + 5);
        send_item(KIND_ALLOC, 16'h0001, $urandom());

        // Random part, one run of requests per pool setting. The table is never cleared
        // between phases, so shrinking the pool under live regions comes about naturally.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       begin cfg_base = 32'h1234_0000; cfg_size = 16'hFFFF; end
                1:       begin cfg_base = 32'hFFFF_FFFF; cfg_size = 16'h0001; end
                2:       begin cfg_base = $urandom(); cfg_size = 16'($urandom_range(1, 65535)); end
                3:       begin cfg_base = 32'h8000_0000; cfg_size = 16'd500; end
                4:       begin cfg_base = 32'h0000_0000; cfg_size = 16'hFFFF; end
                default: begin cfg_base = $urandom(); cfg_size = 16'($urandom_range(1, 4096)); end
            endcase
            configure_pool(cfg_base, cfg_size);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                if (live_ofs.size() == 0 || sel < 50)
                begin
                    // Mostly small requests so that the table fills up, with some sized
                    // against the pool and the odd extreme or wholly random size.
                    case ($urandom_range(0, 9))
                        0:       req = 16'($urandom());
                        1:       req = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                        2, 3:    req = 16'($urandom_range(1, pool_now));
                        default: req = 16'($urandom_range(1, 256));
                    endcase
                    send_item(KIND_ALLOC, req, $urandom());
                end
                else if (sel < 85)
                begin
                    // Free a region the block granted earlier.
                    idx = $urandom_range(0, live_ofs.size() - 1);
                    addr = base_now + live_ofs[idx];
                    live_ofs.delete(idx);
                    send_item(KIND_FREE, 16'($urandom()), addr);
                end
                else if (sel < 92)
                begin
                    // Near miss: just beside the start of a live region.
                    idx = $urandom_range(0, live_ofs.size() - 1);
                    addr = base_now + live_ofs[idx] +
                           (($urandom_range(0, 1) == 1) ? 32'd1 : 32'hFFFF_FFFF);
                    send_item(KIND_FREE, 16'($urandom()), addr);
                end
                else
                    send_item(KIND_FREE, 16'($urandom()), $urandom());

                // Now and then the sender waits for every outstanding result.
                if ($urandom_range(0, 127) == 0)
                    hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
